// ===== design/wpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsm_pkg: shared definitions for the window prefetch slot manager
// Sizes, function codes, register indexes and the controller/datapath link.
// ----------------------------------------------------------------------------
package wpsm_pkg;

  localparam int SLOTS      = 8;
  localparam int PENDING    = 8;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PEND_W     = (PENDING > 1) ? $clog2(PENDING) : 1;
  localparam int WLEN_W     = $clog2(SLOTS + 1);
  localparam int FRAME_W    = 16;
  localparam int SIZE_W     = 32;
  localparam int BYTES_W    = 35;
  localparam int CNT_W      = 32;
  localparam int FUNC_W     = 3;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_SET_WINDOW = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLAIM      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TAKE       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_BYTE_BUDGET = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_MOD_FI,
    CMD_MOD_FRONT,
    CMD_MOD_SLOT,
    CMD_SET_WIN,
    CMD_SET_FM,
    CMD_PRUNE,
    CMD_CLAIM_STEP,
    CMD_COMPLETE,
    CMD_EVICT_INIT,
    CMD_EVICT_SKIP,
    CMD_EVICT_CMP,
    CMD_EVICT_FREE,
    CMD_STORE,
    CMD_TAKE,
    CMD_QUERY,
    CMD_LOAD_OUT
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              mod_done;
    logic              pend_free;
    logic              pend_hit;
    logic              fi_in_range;
    logic              k_more;
    logic              cand_ok;
    logic              wanted_fi;
    logic              need_evict;
    logic              slot_cand;
    logic              ptr_last;
    logic              far_ok;
  } dp_stat_t;

endpackage

// ===== design/wpsm_mod.sv =====
// ----------------------------------------------------------------------------
// wpsm_mod: iterative remainder unit
// Computes dividend mod divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wpsm_mod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wpsm_pkg::FRAME_W-1:0] dividend,
  input  logic [wpsm_pkg::FRAME_W-1:0] divisor,
  output logic                         done,
  output logic [wpsm_pkg::FRAME_W-1:0] rem
);

  localparam int FW = wpsm_pkg::FRAME_W;
  localparam int CW = $clog2(FW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [FW-1:0] dvd_r;
  logic [FW-1:0] rem_r;
  logic [FW:0]   trial;
  logic [FW:0]   diff;
  logic [FW-1:0] rem_nxt;

  // Restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, dvd_r[FW-1]};
    diff    = trial - {1'b0, divisor};
    rem_nxt = (trial >= {1'b0, divisor}) ? diff[FW-1:0] : trial[FW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(FW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[FW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== design/wpsm_dp.sv =====
// ----------------------------------------------------------------------------
// wpsm_dp: slot manager datapath
// Slot and pending tables, window state, byte and decode counters, scratch
// registers for the scans and the result register, driven by commands.
// ----------------------------------------------------------------------------
module wpsm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wpsm_pkg::dp_cmd_t               cmd,
  output wpsm_pkg::dp_stat_t              st,
  input  logic                            cfg_we,
  input  logic [wpsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wpsm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [wpsm_pkg::FUNC_W-1:0]     in_func,
  input  logic [wpsm_pkg::FRAME_W-1:0]    in_frame_index,
  input  logic [wpsm_pkg::FRAME_W-1:0]    in_window_count,
  input  logic [wpsm_pkg::SIZE_W-1:0]     in_picture_bytes,
  output logic                            out_status,
  output logic [wpsm_pkg::FRAME_W-1:0]    out_result_index,
  output logic [wpsm_pkg::SIZE_W-1:0]     out_result_bytes,
  output logic [wpsm_pkg::BYTES_W-1:0]    out_held_bytes,
  output logic [wpsm_pkg::CNT_W-1:0]      out_decode_total
);

  localparam int NS = wpsm_pkg::SLOTS;
  localparam int NP = wpsm_pkg::PENDING;
  localparam int SW = wpsm_pkg::SLOT_W;
  localparam int PW = wpsm_pkg::PEND_W;
  localparam int LW = wpsm_pkg::WLEN_W;
  localparam int FW = wpsm_pkg::FRAME_W;
  localparam int ZW = wpsm_pkg::SIZE_W;
  localparam int BW = wpsm_pkg::BYTES_W;
  localparam int CW = wpsm_pkg::CNT_W;

  // Configuration and architectural state.
  logic [FW-1:0] n_r;
  logic [ZW-1:0] budget_r;
  logic [NS-1:0] slot_valid_r;
  logic [FW-1:0] slot_frame_r [NS];
  logic [ZW-1:0] slot_size_r  [NS];
  logic [NP-1:0] pend_valid_r;
  logic [FW-1:0] pend_frame_r [NP];
  logic [FW-1:0] front_r;
  logic [LW-1:0] wlen_r;
  logic [BW-1:0] bytes_r;
  logic [CW-1:0] dec_r;

  // Request and scratch.
  logic [wpsm_pkg::FUNC_W-1:0] func_r;
  logic [FW-1:0] fi_r;
  logic [FW-1:0] wc_r;
  logic [ZW-1:0] pb_r;
  logic [FW-1:0] fm_r;
  logic [SW-1:0] ptr_r;
  logic [LW-1:0] k_r;
  logic [SW-1:0] pick_r;
  logic          pick_ok_r;
  logic [SW-1:0] far_r;
  logic          far_ok_r;
  logic [FW-1:0] far_d_r;
  logic          stat_r;
  logic [FW-1:0] ridx_r;
  logic [ZW-1:0] rbytes_r;

  // Result register.
  logic          o_status_r;
  logic [FW-1:0] o_idx_r;
  logic [ZW-1:0] o_bytes_r;
  logic [BW-1:0] o_held_r;
  logic [CW-1:0] o_dec_r;

  logic          n_zero;
  logic [PW-1:0] pf_idx;
  logic          pf_ok;
  logic [PW-1:0] ph_idx;
  logic          ph_ok;
  logic [SW-1:0] sf_idx;
  logic          sf_ok;
  logic [SW-1:0] hw_idx;
  logic          hw_ok;
  logic [FW:0]   csum;
  logic [FW-1:0] cidx;
  logic          c_held;
  logic          c_busy;
  logic          claim_ok;
  logic [SW-1:0] rd_idx;
  logic [FW-1:0] rd_frame;
  logic [ZW-1:0] rd_size;
  logic          rd_wanted;
  logic [LW-1:0] lim;
  logic [LW-1:0] wlen_new;
  logic [FW-1:0] ev_d;
  logic [BW:0]   bytes_sum;
  logic          mod_start;
  logic [FW-1:0] mod_dvd;
  logic          mod_done;
  logic [FW-1:0] mod_rem;

  // Forward distance from the front on the circular list; both operands < n.
  function automatic logic [FW-1:0] dist_f(input logic [FW-1:0] a,
                                           input logic [FW-1:0] f,
                                           input logic [FW-1:0] nn);
    logic [FW:0] t;
    begin
      if (a >= f) t = {1'b0, a} - {1'b0, f};
      else t = {1'b0, a} + {1'b0, nn} - {1'b0, f};
      return t[FW-1:0];
    end
  endfunction

  assign n_zero = (n_r == '0);

  // First-match searches over the small tables.
  always_comb begin
    pf_idx = '0;
    pf_ok  = 1'b0;
    ph_idx = '0;
    ph_ok  = 1'b0;
    c_busy = 1'b0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (!pend_valid_r[i]) begin
        pf_idx = PW'(i);
        pf_ok  = 1'b1;
      end
      if (pend_valid_r[i] && pend_frame_r[i] == fi_r) begin
        ph_idx = PW'(i);
        ph_ok  = 1'b1;
      end
      if (pend_valid_r[i] && pend_frame_r[i] == cidx) begin
        c_busy = 1'b1;
      end
    end
  end

  always_comb begin
    sf_idx = '0;
    sf_ok  = 1'b0;
    hw_idx = '0;
    hw_ok  = 1'b0;
    c_held = 1'b0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        sf_idx = SW'(i);
        sf_ok  = 1'b1;
      end
      if (slot_valid_r[i] && slot_frame_r[i] == fi_r) begin
        hw_idx = SW'(i);
        hw_ok  = 1'b1;
      end
      if (slot_valid_r[i] && slot_frame_r[i] == cidx) begin
        c_held = 1'b1;
      end
    end
  end

  // Claim candidate: front plus offset, wrapped once (offset is below n).
  always_comb begin
    csum = {1'b0, fm_r} + (FW + 1)'(k_r);
    if (csum >= {1'b0, n_r}) csum = csum - {1'b0, n_r};
    cidx     = csum[FW-1:0];
    claim_ok = !c_held && !c_busy;
  end

  // One read port into the slot table.
  always_comb begin
    case (cmd)
      wpsm_pkg::CMD_TAKE:       rd_idx = hw_idx;
      wpsm_pkg::CMD_EVICT_FREE: rd_idx = far_r;
      default:                  rd_idx = ptr_r;
    endcase
  end

  assign rd_frame  = slot_frame_r[rd_idx];
  assign rd_size   = slot_size_r[rd_idx];
  assign rd_wanted = !n_zero && (rd_frame < n_r) &&
                     (dist_f(rd_frame, fm_r, n_r) < FW'(wlen_r));

  always_comb begin
    lim      = (n_r < FW'(NS)) ? n_r[LW-1:0] : LW'(NS);
    wlen_new = (wc_r < FW'(lim)) ? wc_r[LW-1:0] : lim;
  end

  assign ev_d      = dist_f(mod_rem, fm_r, n_r);
  assign bytes_sum = {1'b0, bytes_r} + (BW + 1)'(pb_r);

  assign mod_start = (cmd == wpsm_pkg::CMD_MOD_FI) || (cmd == wpsm_pkg::CMD_MOD_FRONT) ||
                     (cmd == wpsm_pkg::CMD_MOD_SLOT);

  always_comb begin
    case (cmd)
      wpsm_pkg::CMD_MOD_FI:    mod_dvd = fi_r;
      wpsm_pkg::CMD_MOD_FRONT: mod_dvd = front_r;
      default:                 mod_dvd = rd_frame;
    endcase
  end

  wpsm_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (n_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    st.func        = func_r;
    st.mod_done    = mod_done;
    st.pend_free   = pf_ok;
    st.pend_hit    = ph_ok;
    st.fi_in_range = !n_zero && (fi_r < n_r);
    st.k_more      = (k_r < wlen_r) && (FW'(k_r) < n_r);
    st.cand_ok     = claim_ok;
    st.wanted_fi   = dist_f(fi_r, fm_r, n_r) < FW'(wlen_r);
    st.need_evict  = !pick_ok_r || (bytes_sum > (BW + 1)'(budget_r));
    st.slot_cand   = slot_valid_r[ptr_r] && !(pick_ok_r && ptr_r == pick_r);
    st.ptr_last    = (ptr_r == SW'(NS - 1));
    st.far_ok      = far_ok_r;
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= '0;
      budget_r     <= '0;
      slot_valid_r <= '0;
      pend_valid_r <= '0;
      front_r      <= '0;
      wlen_r       <= '0;
      bytes_r      <= '0;
      dec_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          wpsm_pkg::REG_FRAME_COUNT: n_r <= cfg_data[FW-1:0];
          wpsm_pkg::REG_BYTE_BUDGET: budget_r <= cfg_data[ZW-1:0];
          default: ;
        endcase
      end
      case (cmd)
        wpsm_pkg::CMD_SET_WIN: begin
          front_r <= n_zero ? '0 : mod_rem;
          wlen_r  <= wlen_new;
        end
        wpsm_pkg::CMD_PRUNE: begin
          if (slot_valid_r[ptr_r] && !rd_wanted) begin
            slot_valid_r[ptr_r] <= 1'b0;
            bytes_r             <= bytes_r - BW'(rd_size);
          end
        end
        wpsm_pkg::CMD_CLAIM_STEP: begin
          if (claim_ok) pend_valid_r[pf_idx] <= 1'b1;
        end
        wpsm_pkg::CMD_COMPLETE: begin
          pend_valid_r[ph_idx] <= 1'b0;
          dec_r                <= dec_r + CW'(1);
        end
        wpsm_pkg::CMD_EVICT_FREE: begin
          slot_valid_r[far_r] <= 1'b0;
          bytes_r             <= bytes_r - BW'(rd_size);
        end
        wpsm_pkg::CMD_STORE: begin
          if (pick_ok_r) begin
            slot_valid_r[pick_r] <= 1'b1;
            bytes_r              <= bytes_sum[BW-1:0];
          end
        end
        wpsm_pkg::CMD_TAKE: begin
          if (hw_ok) begin
            slot_valid_r[hw_idx] <= 1'b0;
            bytes_r              <= bytes_r - BW'(rd_size);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: table entries, request, scratch and result.
  always_ff @(posedge clk) begin
    case (cmd)
      wpsm_pkg::CMD_LATCH: begin
        func_r   <= in_func;
        fi_r     <= in_frame_index;
        wc_r     <= in_window_count;
        pb_r     <= in_picture_bytes;
        stat_r   <= 1'b1;
        ridx_r   <= '0;
        rbytes_r <= '0;
        ptr_r    <= '0;
        k_r      <= '0;
      end
      wpsm_pkg::CMD_SET_WIN: begin
        fm_r   <= n_zero ? '0 : mod_rem;
        ptr_r  <= '0;
        stat_r <= 1'b0;
      end
      wpsm_pkg::CMD_SET_FM: begin
        fm_r <= mod_rem;
        k_r  <= '0;
      end
      wpsm_pkg::CMD_PRUNE: ptr_r <= ptr_r + SW'(1);
      wpsm_pkg::CMD_CLAIM_STEP: begin
        if (claim_ok) begin
          pend_frame_r[pf_idx] <= cidx;
          stat_r               <= 1'b0;
          ridx_r               <= cidx;
        end else begin
          k_r <= k_r + LW'(1);
        end
      end
      wpsm_pkg::CMD_COMPLETE: begin
        pick_r    <= sf_idx;
        pick_ok_r <= sf_ok;
      end
      wpsm_pkg::CMD_EVICT_INIT: begin
        far_ok_r <= 1'b0;
        ptr_r    <= '0;
      end
      wpsm_pkg::CMD_EVICT_SKIP: ptr_r <= ptr_r + SW'(1);
      wpsm_pkg::CMD_EVICT_CMP: begin
        // Strictly farther wins, so the first slot keeps a tie.
        if (!far_ok_r || ev_d > far_d_r) begin
          far_r    <= ptr_r;
          far_d_r  <= ev_d;
          far_ok_r <= 1'b1;
        end
        ptr_r <= ptr_r + SW'(1);
      end
      wpsm_pkg::CMD_EVICT_FREE: begin
        if (!pick_ok_r) begin
          pick_r    <= far_r;
          pick_ok_r <= 1'b1;
        end
      end
      wpsm_pkg::CMD_STORE: begin
        if (pick_ok_r) begin
          slot_frame_r[pick_r] <= fi_r;
          slot_size_r[pick_r]  <= pb_r;
        end
        stat_r <= 1'b0;
      end
      wpsm_pkg::CMD_TAKE: begin
        if (hw_ok) begin
          rbytes_r <= rd_size;
          stat_r   <= 1'b0;
        end
      end
      wpsm_pkg::CMD_QUERY: begin
        if (hw_ok) stat_r <= 1'b0;
      end
      wpsm_pkg::CMD_LOAD_OUT: begin
        o_status_r <= stat_r;
        o_idx_r    <= ridx_r;
        o_bytes_r  <= rbytes_r;
        o_held_r   <= bytes_r;
        o_dec_r    <= dec_r;
      end
      default: ;
    endcase
  end

  assign out_status       = o_status_r;
  assign out_result_index = o_idx_r;
  assign out_result_bytes = o_bytes_r;
  assign out_held_bytes   = o_held_r;
  assign out_decode_total = o_dec_r;

  // Held bytes move only under a command, never on their own.
  a_bytes_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == wpsm_pkg::CMD_NONE) |=> (bytes_r == $past(bytes_r)))
    else $error("held byte total changed without a command");

endmodule

// ===== design/wpsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpsm_ctrl: slot manager controller
// Sequences each request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module wpsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  wpsm_pkg::dp_stat_t st,
  output wpsm_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FI_WAIT,
    S_PRUNE,
    S_CLAIM_FM,
    S_CLAIM,
    S_CHK_WANT,
    S_WANT_FM,
    S_WANT_TEST,
    S_EV_CHECK,
    S_EV_SCAN,
    S_EV_WAIT,
    S_EV_END,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = wpsm_pkg::CMD_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = wpsm_pkg::CMD_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.func)
          wpsm_pkg::FUNC_SET_WINDOW: begin
            cmd       = wpsm_pkg::CMD_MOD_FI;
            state_nxt = S_FI_WAIT;
          end
          wpsm_pkg::FUNC_CLAIM: begin
            if (st.pend_free) begin
              cmd       = wpsm_pkg::CMD_MOD_FRONT;
              state_nxt = S_CLAIM_FM;
            end else begin
              state_nxt = S_DONE;
            end
          end
          wpsm_pkg::FUNC_COMPLETE: begin
            if (st.pend_hit) begin
              cmd       = wpsm_pkg::CMD_COMPLETE;
              state_nxt = S_CHK_WANT;
            end else begin
              state_nxt = S_DONE;
            end
          end
          wpsm_pkg::FUNC_TAKE: begin
            cmd       = wpsm_pkg::CMD_TAKE;
            state_nxt = S_DONE;
          end
          wpsm_pkg::FUNC_QUERY: begin
            cmd       = wpsm_pkg::CMD_QUERY;
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FI_WAIT: begin
        if (st.mod_done) begin
          cmd       = wpsm_pkg::CMD_SET_WIN;
          state_nxt = S_PRUNE;
        end
      end
      S_PRUNE: begin
        cmd = wpsm_pkg::CMD_PRUNE;
        if (st.ptr_last) state_nxt = S_DONE;
      end
      S_CLAIM_FM: begin
        if (st.mod_done) begin
          cmd       = wpsm_pkg::CMD_SET_FM;
          state_nxt = S_CLAIM;
        end
      end
      S_CLAIM: begin
        if (!st.k_more) begin
          state_nxt = S_DONE;
        end else begin
          cmd = wpsm_pkg::CMD_CLAIM_STEP;
          if (st.cand_ok) state_nxt = S_DONE;
        end
      end
      S_CHK_WANT: begin
        if (st.fi_in_range) begin
          cmd       = wpsm_pkg::CMD_MOD_FRONT;
          state_nxt = S_WANT_FM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WANT_FM: begin
        if (st.mod_done) begin
          cmd       = wpsm_pkg::CMD_SET_FM;
          state_nxt = S_WANT_TEST;
        end
      end
      S_WANT_TEST: begin
        state_nxt = st.wanted_fi ? S_EV_CHECK : S_DONE;
      end
      S_EV_CHECK: begin
        if (st.need_evict) begin
          cmd       = wpsm_pkg::CMD_EVICT_INIT;
          state_nxt = S_EV_SCAN;
        end else begin
          cmd       = wpsm_pkg::CMD_STORE;
          state_nxt = S_DONE;
        end
      end
      S_EV_SCAN: begin
        if (st.slot_cand) begin
          cmd       = wpsm_pkg::CMD_MOD_SLOT;
          state_nxt = S_EV_WAIT;
        end else begin
          cmd = wpsm_pkg::CMD_EVICT_SKIP;
          if (st.ptr_last) state_nxt = S_EV_END;
        end
      end
      S_EV_WAIT: begin
        if (st.mod_done) begin
          cmd       = wpsm_pkg::CMD_EVICT_CMP;
          state_nxt = st.ptr_last ? S_EV_END : S_EV_SCAN;
        end
      end
      S_EV_END: begin
        if (st.far_ok) begin
          cmd       = wpsm_pkg::CMD_EVICT_FREE;
          state_nxt = S_EV_CHECK;
        end else begin
          cmd       = wpsm_pkg::CMD_STORE;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd           = wpsm_pkg::CMD_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_take_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_DECODE))
    else $error("accepted request was not decoded");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("result overwrote an undelivered one");

  a_mod_wait: assert property (@(posedge clk) disable iff (!rst_n)
    st.mod_done |-> (state_r == S_FI_WAIT || state_r == S_CLAIM_FM ||
                     state_r == S_WANT_FM || state_r == S_EV_WAIT))
    else $error("remainder finished outside a wait state");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised without a finished request");

endmodule

// ===== design/window_prefetch_slot_manager.sv =====
// ----------------------------------------------------------------------------
// window_prefetch_slot_manager: sliding-window prefetch slot table
// Keeps held pictures and pending decodes for a circular list of frames,
// with window pruning, claim, completion with byte-budget eviction, take
// and query requests.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   in_      in_valid / in_stall   func, frame_index, window_count, picture_bytes
//   out_     out_valid / out_stall status, result_index, result_bytes,
//                                  held_bytes, decode_total
//   cfg_     cfg_valid / cfg_ready cfg_addr (0 frame_count, 1 byte_budget), cfg_data
//
// One request is worked on at a time. Frame indexes are reduced modulo
// frame_count in a shared remainder unit; the claim candidate and the
// window distances wrap by plain arithmetic instead. A completion
// that evicts rescans the held slots through the remainder unit in
// every eviction round. Reset clears all control state at once; there is
// no clearing pass. A stalled result stays in the output register; the
// next request may be taken meanwhile and finishes into that register
// once it drains. cfg_ready is always high; configuration is to be
// written by the user only while the block is idle, as the block
// itself does not enforce it.
//
module window_prefetch_slot_manager (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wpsm_pkg::FUNC_W-1:0]     in_func,
  input  logic [wpsm_pkg::FRAME_W-1:0]    in_frame_index,
  input  logic [wpsm_pkg::FRAME_W-1:0]    in_window_count,
  input  logic [wpsm_pkg::SIZE_W-1:0]     in_picture_bytes,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status,
  output logic [wpsm_pkg::FRAME_W-1:0]    out_result_index,
  output logic [wpsm_pkg::SIZE_W-1:0]     out_result_bytes,
  output logic [wpsm_pkg::BYTES_W-1:0]    out_held_bytes,
  output logic [wpsm_pkg::CNT_W-1:0]      out_decode_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wpsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wpsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  wpsm_pkg::dp_cmd_t  cmd;
  wpsm_pkg::dp_stat_t st;

  // The register file never pushes back.
  assign cfg_ready = 1'b1;

  // The controller decides what happens each cycle; the datapath only
  // executes the command it is given and reports flags back.
  wpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  wpsm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_we           (cfg_valid),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .in_func          (in_func),
    .in_frame_index   (in_frame_index),
    .in_window_count  (in_window_count),
    .in_picture_bytes (in_picture_bytes),
    .out_status       (out_status),
    .out_result_index (out_result_index),
    .out_result_bytes (out_result_bytes),
    .out_held_bytes   (out_held_bytes),
    .out_decode_total (out_decode_total)
  );

endmodule
